[sv/assert_macros.svh]
// Assertion macros shared by the segmentation RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[sv/gbis_pkg.sv]
// Shared types, constants and command codes of the graph segmentation core.
// No dependencies; imported by every other file but gbis_ram and assert_macros.svh.
`timescale 1ns / 1ps
package gbis_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES_DEF = 4096;
  localparam int WEIGHT_BITS = 16;
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int SIZE_W = $clog2(MAX_VERTICES + 1);
  localparam int K_W = 24;
  localparam int THR_W = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_SCALED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd2;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_QUERY = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_LABEL = 1'b1;

  localparam logic [SIZE_W-1:0] VCOUNT_RST = SIZE_W'(1024);
  localparam logic [K_W-1:0] K_RST = K_W'(76800);
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST = SIZE_W'(20);

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [VIDX_W-1:0] dst;
    logic [VIDX_W-1:0] src;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_QUERY, OP_CLR, OP_SORT_INIT, OP_M_RUN, OP_M_RDP,
    OP_M_RDQ, OP_M_LQ, OP_M_TAKE, OP_M_FP, OP_M_FQ, OP_M_NEXT, OP_P_START,
    OP_P_PASS2, OP_P_NEXT, OP_P_EDGE, OP_FIND_HOP, OP_ROOT_A, OP_ROOT_B,
    OP_SZ_B, OP_DEC, OP_JOIN, OP_DIV_START, OP_THR_WR, OP_FIN, OP_Q_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic n_le1;
    logic lo_ge_n;
    logic wid_last;
    logic take_done;
    logic take_q;
    logic i_ge_n;
    logic pass2;
    logic edge_ok;
    logic par_eq_cur;
    logic same_root;
    logic merge;
    logic div_done;
    logic out_free;
    logic q_ok;
  } dp_status_t;

endpackage

[sv/gbis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the edge buffers and the forest tables.
`timescale 1ns / 1ps
module gbis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/gbis_div.sv]
// Restoring divider, one quotient bit per cycle, for k over component size.
// Depends on gbis_pkg for the operand widths.
`timescale 1ns / 1ps
module gbis_div import gbis_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [K_W-1:0]    dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [K_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(K_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [K_W-1:0]    quo_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] dvs_r;
  logic [SIZE_W:0]   trial;
  logic              ge;
  logic [SIZE_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[K_W-1]};
    ge = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? SIZE_W'(trial - {1'b0, dvs_r}) : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(K_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[K_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

[sv/gbis_ctrl.sv]
// Sequencer of the segmentation core: loads, queries, forest clear, merge
// sort and the two merge passes. Depends on gbis_pkg; drives gbis_dp.
`timescale 1ns / 1ps
module gbis_ctrl import gbis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  input  logic       in_last,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_RCLR, S_IDLE, S_SCLR, S_SINIT, S_MRUN, S_MRDP, S_MRDQ, S_MLQ, S_MSTEP,
    S_MFP, S_MFQ, S_PSTART, S_PNEXT, S_PEDGE, S_FA, S_FB, S_SZB, S_DEC,
    S_JOIN, S_DIVS, S_DIVW, S_FIN, S_QFIND, S_QOUT
  } state_t;

  state_t state_r, state_nxt;
  dp_op_e op;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    op = OP_NONE;
    case (state_r)
      S_RCLR: begin
        op = OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op == OPER_QUERY) begin
            op = OP_QUERY;
            state_nxt = S_QFIND;
          end else begin
            op = OP_LOAD;
            if (in_last) state_nxt = S_SCLR;
          end
        end
      end
      S_SCLR: begin
        op = OP_CLR;
        if (sts.clr_last) state_nxt = S_SINIT;
      end
      S_SINIT: begin
        op = OP_SORT_INIT;
        state_nxt = sts.n_le1 ? S_PSTART : S_MRUN;
      end
      S_MRUN: begin
        op = OP_M_RUN;
        if (!sts.lo_ge_n) state_nxt = S_MRDP;
        else if (sts.wid_last) state_nxt = S_PSTART;
      end
      S_MRDP: begin
        op = OP_M_RDP;
        state_nxt = S_MRDQ;
      end
      S_MRDQ: begin
        op = OP_M_RDQ;
        state_nxt = S_MLQ;
      end
      S_MLQ: begin
        op = OP_M_LQ;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        if (sts.take_done) begin
          op = OP_M_NEXT;
          state_nxt = S_MRUN;
        end else begin
          op = OP_M_TAKE;
          state_nxt = sts.take_q ? S_MFQ : S_MFP;
        end
      end
      S_MFP: begin
        op = OP_M_FP;
        state_nxt = S_MSTEP;
      end
      S_MFQ: begin
        op = OP_M_FQ;
        state_nxt = S_MSTEP;
      end
      S_PSTART: begin
        op = OP_P_START;
        state_nxt = S_PNEXT;
      end
      S_PNEXT: begin
        if (sts.i_ge_n) begin
          if (sts.pass2) state_nxt = S_FIN;
          else op = OP_P_PASS2;
        end else begin
          op = OP_P_NEXT;
          state_nxt = S_PEDGE;
        end
      end
      S_PEDGE: begin
        op = OP_P_EDGE;
        state_nxt = sts.edge_ok ? S_FA : S_PNEXT;
      end
      S_FA: begin
        if (sts.par_eq_cur) begin
          op = OP_ROOT_A;
          state_nxt = S_FB;
        end else begin
          op = OP_FIND_HOP;
        end
      end
      S_FB: begin
        if (sts.par_eq_cur) begin
          op = OP_ROOT_B;
          state_nxt = sts.same_root ? S_PNEXT : S_SZB;
        end else begin
          op = OP_FIND_HOP;
        end
      end
      S_SZB: begin
        op = OP_SZ_B;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        op = OP_DEC;
        state_nxt = S_JOIN;
      end
      S_JOIN: begin
        op = OP_JOIN;
        state_nxt = (sts.merge && !sts.pass2) ? S_DIVS : S_PNEXT;
      end
      S_DIVS: begin
        op = OP_DIV_START;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          op = OP_THR_WR;
          state_nxt = S_PNEXT;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          op = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_QFIND: begin
        if (!sts.q_ok || sts.par_eq_cur) state_nxt = S_QOUT;
        else op = OP_FIND_HOP;
      end
      S_QOUT: begin
        if (sts.out_free) begin
          op = OP_Q_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.op = op;

endmodule

[sv/gbis_dp.sv]
// Datapath of the segmentation core: configuration, edge buffers, forest
// tables, sort and pass counters, divider and output register.
// Depends on gbis_pkg, gbis_ram, gbis_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbis_dp import gbis_pkg::*; #(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  edge_t                 in_edge,
  input  logic [VIDX_W-1:0]     in_query,
  input  logic                  out_tready,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [VIDX_W-1:0]     out_label,
  output logic                  out_dropped,
  input  dp_cmd_t               cmd,
  output dp_status_t            sts
);

  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = ETW + 2;

  logic [SIZE_W-1:0] vcnt_r, mins_r, vc_act;
  logic [K_W-1:0]    k_r;

  logic [ETW-1:0]    et_r, et_nxt;
  logic              ovf_r, ovf_nxt;
  logic [VIDX_W-1:0] ci_r, ci_nxt;
  logic              sel_r, sel_nxt;
  logic              ovld_r, ovld_nxt;
  logic              pass2_r, pass2_nxt;

  logic [CW-1:0]     wid_r, wid_nxt, lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0]     p_r, p_nxt, q_r, q_nxt, o_r, o_nxt;
  edge_t             hp_r, hp_nxt, hq_r, hq_nxt, er_r, er_nxt;
  logic [ETW-1:0]    i_r, i_nxt;
  logic [VIDX_W-1:0] cur_r, cur_nxt, ra_r, ra_nxt, rb_r, rb_nxt, keep_r, keep_nxt;
  logic [SIZE_W-1:0] sa_r, sa_nxt, sb_r, sb_nxt, nsz_r, nsz_nxt;
  logic [THR_W-1:0]  ta_r, ta_nxt, tb_r, tb_nxt;
  logic              okind_r, okind_nxt, odrop_r, odrop_nxt;
  logic [VIDX_W-1:0] olab_r, olab_nxt;

  logic [CW-1:0]     n_c, mid_c, hi_c, p_inc, q_inc;
  logic              p_lt_mid, q_lt_hi, take_q, et_lt_max, b_wins, merge;
  edge_t             pick, erd, a_rdata, b_rdata;
  logic [EDGE_W-1:0] a_rd_raw, b_rd_raw;

  logic              a_we, b_we, par_we, siz_we, thr_we;
  logic [EAW-1:0]    a_waddr, e_raddr;
  edge_t             a_wdata;
  logic [VIDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata, siz_waddr, thr_waddr;
  logic [VIDX_W-1:0] srd_addr;
  logic [SIZE_W-1:0] siz_wdata, siz_rdata;
  logic [THR_W-1:0]  thr_wdata, thr_rdata;
  logic              div_done;
  logic [K_W-1:0]    div_quo;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= VCOUNT_RST;
      k_r <= K_RST;
      mins_r <= MIN_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vcnt_r <= cfg_data[SIZE_W-1:0];
        CFG_K_SCALED:     k_r <= cfg_data[K_W-1:0];
        CFG_MIN_SIZE:     mins_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcnt_r == '0) vc_act = SIZE_W'(1);
    else if (vcnt_r > SIZE_W'(MAX_VERTICES)) vc_act = SIZE_W'(MAX_VERTICES);
    else vc_act = vcnt_r;
  end

  assign a_rdata = edge_t'(a_rd_raw);
  assign b_rdata = edge_t'(b_rd_raw);
  assign erd = sel_r ? b_rdata : a_rdata;

  always_comb begin
    n_c = CW'(et_r);
    mid_c = ((lo_r + wid_r) < n_c) ? (lo_r + wid_r) : n_c;
    hi_c = ((mid_c + wid_r) < n_c) ? (mid_c + wid_r) : n_c;
    p_inc = p_r + CW'(1);
    q_inc = q_r + CW'(1);
    p_lt_mid = p_r < mid_r;
    q_lt_hi = q_r < hi_r;
    // Ties go to the left run, which keeps the sort stable in load order.
    take_q = q_lt_hi && (!p_lt_mid || (hq_r.weight < hp_r.weight));
    pick = take_q ? hq_r : hp_r;
    et_lt_max = et_r < ETW'(MAX_EDGES);
    b_wins = (sb_r > sa_r) || ((sb_r == sa_r) && (rb_r < ra_r));
    if (pass2_r) merge = (sa_r < mins_r) || (sb_r < mins_r);
    else merge = (THR_W'(er_r.weight) <= ta_r) && (THR_W'(er_r.weight) <= tb_r);
  end

  always_comb begin
    et_nxt = et_r;
    ovf_nxt = ovf_r;
    ci_nxt = ci_r;
    sel_nxt = sel_r;
    ovld_nxt = ovld_r && !out_tready;
    pass2_nxt = pass2_r;
    wid_nxt = wid_r;
    lo_nxt = lo_r;
    mid_nxt = mid_r;
    hi_nxt = hi_r;
    p_nxt = p_r;
    q_nxt = q_r;
    o_nxt = o_r;
    hp_nxt = hp_r;
    hq_nxt = hq_r;
    er_nxt = er_r;
    i_nxt = i_r;
    cur_nxt = cur_r;
    ra_nxt = ra_r;
    rb_nxt = rb_r;
    keep_nxt = keep_r;
    sa_nxt = sa_r;
    sb_nxt = sb_r;
    nsz_nxt = nsz_r;
    ta_nxt = ta_r;
    tb_nxt = tb_r;
    okind_nxt = okind_r;
    olab_nxt = olab_r;
    odrop_nxt = odrop_r;
    a_we = 1'b0;
    b_we = 1'b0;
    a_waddr = et_r[EAW-1:0];
    a_wdata = in_edge;
    e_raddr = '0;
    par_we = 1'b0;
    par_waddr = ci_r;
    par_wdata = ci_r;
    par_raddr = '0;
    siz_we = 1'b0;
    siz_waddr = ci_r;
    siz_wdata = SIZE_W'(1);
    thr_we = 1'b0;
    thr_waddr = ci_r;
    thr_wdata = THR_W'(k_r);
    srd_addr = '0;
    case (cmd.op)
      OP_LOAD: begin
        // The first edge of a new graph clears the overflow mark.
        if (et_r == '0) ovf_nxt = 1'b0;
        if (et_lt_max) begin
          a_we = 1'b1;
          et_nxt = et_r + ETW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_QUERY: begin
        cur_nxt = in_query;
        par_raddr = in_query;
      end
      OP_CLR: begin
        par_we = 1'b1;
        siz_we = 1'b1;
        thr_we = 1'b1;
        ci_nxt = (ci_r == VIDX_W'(MAX_VERTICES - 1)) ? '0 : ci_r + VIDX_W'(1);
      end
      OP_SORT_INIT: begin
        wid_nxt = CW'(1);
        lo_nxt = '0;
        sel_nxt = 1'b0;
      end
      OP_M_RUN: begin
        if (lo_r >= n_c) begin
          sel_nxt = !sel_r;
          wid_nxt = wid_r << 1;
          lo_nxt = '0;
        end else begin
          mid_nxt = mid_c;
          hi_nxt = hi_c;
          p_nxt = lo_r;
          q_nxt = mid_c;
          o_nxt = lo_r;
        end
      end
      OP_M_RDP: e_raddr = p_r[EAW-1:0];
      OP_M_RDQ: begin
        hp_nxt = erd;
        e_raddr = q_r[EAW-1:0];
      end
      OP_M_LQ: hq_nxt = erd;
      OP_M_TAKE: begin
        a_we = sel_r;
        b_we = !sel_r;
        a_waddr = o_r[EAW-1:0];
        a_wdata = pick;
        o_nxt = o_r + CW'(1);
        if (take_q) begin
          q_nxt = q_inc;
          e_raddr = q_inc[EAW-1:0];
        end else begin
          p_nxt = p_inc;
          e_raddr = p_inc[EAW-1:0];
        end
      end
      OP_M_FP: hp_nxt = erd;
      OP_M_FQ: hq_nxt = erd;
      OP_M_NEXT: lo_nxt = lo_r + (wid_r << 1);
      OP_P_START: begin
        i_nxt = '0;
        pass2_nxt = 1'b0;
      end
      OP_P_PASS2: begin
        i_nxt = '0;
        pass2_nxt = 1'b1;
      end
      OP_P_NEXT: begin
        e_raddr = i_r[EAW-1:0];
        i_nxt = i_r + ETW'(1);
      end
      OP_P_EDGE: begin
        er_nxt = erd;
        cur_nxt = erd.src;
        par_raddr = erd.src;
      end
      OP_FIND_HOP: begin
        cur_nxt = par_rdata;
        par_raddr = par_rdata;
      end
      OP_ROOT_A: begin
        ra_nxt = cur_r;
        cur_nxt = er_r.dst;
        par_raddr = er_r.dst;
      end
      OP_ROOT_B: begin
        rb_nxt = cur_r;
        srd_addr = ra_r;
      end
      OP_SZ_B: begin
        sa_nxt = siz_rdata;
        ta_nxt = thr_rdata;
        srd_addr = rb_r;
      end
      OP_DEC: begin
        sb_nxt = siz_rdata;
        tb_nxt = thr_rdata;
      end
      OP_JOIN: begin
        if (merge) begin
          par_we = 1'b1;
          siz_we = 1'b1;
          par_waddr = b_wins ? ra_r : rb_r;
          par_wdata = b_wins ? rb_r : ra_r;
          siz_waddr = b_wins ? rb_r : ra_r;
          siz_wdata = sa_r + sb_r;
          keep_nxt = b_wins ? rb_r : ra_r;
          nsz_nxt = sa_r + sb_r;
        end
      end
      OP_THR_WR: begin
        thr_we = 1'b1;
        thr_waddr = keep_r;
        thr_wdata = THR_W'(er_r.weight) + THR_W'(div_quo);
      end
      OP_FIN: begin
        ovld_nxt = 1'b1;
        okind_nxt = KIND_DONE;
        olab_nxt = '0;
        odrop_nxt = ovf_r;
        et_nxt = '0;
      end
      OP_Q_OUT: begin
        ovld_nxt = 1'b1;
        okind_nxt = KIND_LABEL;
        olab_nxt = cur_r;
        odrop_nxt = ovf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      et_r <= '0;
      ovf_r <= 1'b0;
      ci_r <= '0;
      sel_r <= 1'b0;
      ovld_r <= 1'b0;
      pass2_r <= 1'b0;
    end else begin
      et_r <= et_nxt;
      ovf_r <= ovf_nxt;
      ci_r <= ci_nxt;
      sel_r <= sel_nxt;
      ovld_r <= ovld_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wid_r <= wid_nxt;
    lo_r <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r <= hi_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    o_r <= o_nxt;
    hp_r <= hp_nxt;
    hq_r <= hq_nxt;
    er_r <= er_nxt;
    i_r <= i_nxt;
    cur_r <= cur_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    keep_r <= keep_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    nsz_r <= nsz_nxt;
    ta_r <= ta_nxt;
    tb_r <= tb_nxt;
    okind_r <= okind_nxt;
    olab_r <= olab_nxt;
    odrop_r <= odrop_nxt;
  end

  gbis_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_buf_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(e_raddr), .rdata(a_rd_raw)
  );

  gbis_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_buf_b (
    .clk(clk), .we(b_we), .waddr(o_r[EAW-1:0]), .wdata(pick),
    .raddr(e_raddr), .rdata(b_rd_raw)
  );

  gbis_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  gbis_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_VERTICES)) u_size (
    .clk(clk), .we(siz_we), .waddr(siz_waddr), .wdata(siz_wdata),
    .raddr(srd_addr), .rdata(siz_rdata)
  );

  gbis_ram #(.WIDTH(THR_W), .DEPTH(MAX_VERTICES)) u_thresh (
    .clk(clk), .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
    .raddr(srd_addr), .rdata(thr_rdata)
  );

  gbis_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_DIV_START),
    .dividend(k_r), .divisor(nsz_r), .done(div_done), .quotient(div_quo)
  );

  always_comb begin
    sts.clr_last = (ci_r == VIDX_W'(MAX_VERTICES - 1));
    sts.n_le1 = et_r <= ETW'(1);
    sts.lo_ge_n = lo_r >= n_c;
    sts.wid_last = (wid_r << 1) >= n_c;
    sts.take_done = !p_lt_mid && !q_lt_hi;
    sts.take_q = take_q;
    sts.i_ge_n = i_r >= et_r;
    sts.pass2 = pass2_r;
    sts.edge_ok = (SIZE_W'(erd.src) < vc_act) && (SIZE_W'(erd.dst) < vc_act);
    sts.par_eq_cur = par_rdata == cur_r;
    sts.same_root = cur_r == ra_r;
    sts.merge = merge;
    sts.div_done = div_done;
    sts.out_free = !ovld_r || out_tready;
    sts.q_ok = SIZE_W'(cur_r) < vc_act;
  end

  assign out_valid = ovld_r;
  assign out_kind = okind_r;
  assign out_label = olab_r;
  assign out_dropped = odrop_r;

  `ASSERT_NEVER(a_et_cap, et_r > ETW'(MAX_EDGES), "edge count beyond capacity")
  `ASSERT_ALWAYS(a_take_live, (cmd.op == OP_M_TAKE) |-> (p_lt_mid || q_lt_hi), "merge step with both runs empty")
  `ASSERT_ALWAYS(a_thr_done, (cmd.op == OP_THR_WR) |-> div_done, "threshold written before quotient ready")
  `ASSERT_ALWAYS(a_out_free, ((cmd.op == OP_FIN) || (cmd.op == OP_Q_OUT)) |-> (!ovld_r || out_tready), "result overwrites pending beat")

endmodule

[sv/graph_based_image_segmentation_core.sv]
// Graph segmentation core: an edge beat with operation 0 stores the edge
// (src, dest, weight); the beat with tlast set also clears the forest
// tables, sorts the stored edges by weight (stable merge sort over
// ceil(log2 n) levels), runs the threshold pass and the minimum-size pass
// (the first pass uses the bit-serial divider for each merge), then returns
// a finished beat. A query beat (operation 1) returns the root label of the
// queried vertex by following its parent links, or the vertex itself when
// it is not below the vertex count.
// After reset a clearing pass over the forest tables runs before the first
// beat is taken.
`timescale 1ns / 1ps
module graph_based_image_segmentation_core import gbis_pkg::*; #(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] edge_src, [19:10] edge_dest, [35:20] edge_weight, [45:36] query_vertex
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] label, [10] edges_dropped
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] result_kind
  output logic                  out_tuser
);

  dp_cmd_t           cmd;
  dp_status_t        sts;
  edge_t             in_edge;
  logic [VIDX_W-1:0] out_label;
  logic              out_dropped;

  assign cfg_ready = 1'b1;
  assign in_edge.src = in_tdata[9:0];
  assign in_edge.dst = in_tdata[19:10];
  assign in_edge.weight = in_tdata[35:20];

  gbis_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_op(in_tuser),
    .in_last(in_tlast), .in_ready(in_tready), .sts(sts), .cmd(cmd)
  );

  gbis_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_edge(in_edge),
    .in_query(in_tdata[45:36]), .out_tready(out_tready), .out_valid(out_tvalid),
    .out_kind(out_tuser), .out_label(out_label), .out_dropped(out_dropped),
    .cmd(cmd), .sts(sts)
  );

  assign out_tdata = {(OUT_DATA_W - VIDX_W - 1)'(0), out_dropped, out_label};

endmodule

[tb/sv/tb_graph_based_image_segmentation_core.sv]
// Self-checking bench for the graph segmentation core: it loads directed and random graphs,
// checks the finished beat and the labels of queried vertices against a local
// union-find predictor. Depends on gbis_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_graph_based_image_segmentation_core;
  import gbis_pkg::*;

  localparam int EDGE_CAP = MAX_EDGES_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  graph_based_image_segmentation_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic oper;
    logic [9:0] src;
    logic [9:0] dst;
    logic [15:0] weight;
    logic last;
    logic [9:0] qvert;
    bit drain;
  } beat_t;

  typedef struct {
    logic kind;
    logic [9:0] label;
    logic dropped;
  } answer_t;

  beat_t pending_beats[$];
  answer_t awaited_answers[$];
  beat_t cur_beat;
  bit beat_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned random_beats = 0;

  // Predictor state.
  logic [9:0] edge_src_mem[EDGE_CAP];
  logic [9:0] edge_dst_mem[EDGE_CAP];
  logic [15:0] edge_wt_mem[EDGE_CAP];
  int unsigned stored_edges = 0;
  bit drop_flag = 1'b0;
  int unsigned parent_of[MAX_VERTICES];
  int unsigned comp_size[MAX_VERTICES];
  longint unsigned comp_thr[MAX_VERTICES];
  int unsigned vcount_reg = 1024;
  longint unsigned k_reg = 76800;
  int unsigned minsize_reg = 20;

  function automatic int unsigned live_vertices();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
    return vcount_reg;
  endfunction

  function automatic void reset_forest();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      parent_of[v] = v;
      comp_size[v] = 1;
      comp_thr[v] = k_reg;
    end
  endfunction

  function automatic int unsigned find_root(int unsigned v);
    while (parent_of[v] != v) begin
      parent_of[v] = parent_of[parent_of[v]];
      v = parent_of[v];
    end
    return v;
  endfunction

  function automatic int unsigned unite(int unsigned a, int unsigned b);
    int unsigned keep;
    int unsigned gone;
    keep = a;
    gone = b;
    if (comp_size[b] > comp_size[a] || (comp_size[b] == comp_size[a] && b < a)) begin
      keep = b;
      gone = a;
    end
    parent_of[gone] = keep;
    comp_size[keep] += comp_size[gone];
    return keep;
  endfunction

  function automatic void segment_graph();
    longint unsigned keys[$];
    int unsigned order[$];
    int unsigned vc;
    int unsigned e;
    int unsigned a;
    int unsigned b;
    int unsigned r;
    vc = live_vertices();
    // Weight in the high bits and load index below makes the sort stable.
    for (int i = 0; i < stored_edges; i++)
      keys.push_back((longint'(edge_wt_mem[i]) << 16) | i);
    keys.sort();
    foreach (keys[i]) order.push_back(keys[i] & 16'hFFFF);
    reset_forest();
    foreach (order[i]) begin
      e = order[i];
      if (edge_src_mem[e] < vc && edge_dst_mem[e] < vc) begin
        a = find_root(edge_src_mem[e]);
        b = find_root(edge_dst_mem[e]);
        if (a != b && edge_wt_mem[e] <= comp_thr[a] && edge_wt_mem[e] <= comp_thr[b]) begin
          r = unite(a, b);
          comp_thr[r] = edge_wt_mem[e] + k_reg / comp_size[r];
        end
      end
    end
    foreach (order[i]) begin
      e = order[i];
      if (edge_src_mem[e] < vc && edge_dst_mem[e] < vc) begin
        a = find_root(edge_src_mem[e]);
        b = find_root(edge_dst_mem[e]);
        if (a != b && (comp_size[a] < minsize_reg || comp_size[b] < minsize_reg))
          void'(unite(a, b));
      end
    end
  endfunction

  function automatic void predict_beat(beat_t bt);
    answer_t ans;
    if (bt.oper == OPER_LOAD) begin
      if (stored_edges == 0) drop_flag = 1'b0;
      if (stored_edges < EDGE_CAP) begin
        edge_src_mem[stored_edges] = bt.src;
        edge_dst_mem[stored_edges] = bt.dst;
        edge_wt_mem[stored_edges] = bt.weight;
        stored_edges++;
      end else begin
        drop_flag = 1'b1;
      end
      if (bt.last) begin
        segment_graph();
        stored_edges = 0;
        ans.kind = KIND_DONE;
        ans.label = '0;
        ans.dropped = drop_flag;
        awaited_answers.push_back(ans);
      end
    end else begin
      ans.kind = KIND_LABEL;
      ans.label = (bt.qvert < live_vertices()) ? 10'(find_root(bt.qvert)) : bt.qvert;
      ans.dropped = drop_flag;
      awaited_answers.push_back(ans);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sampling and the timeout live on the rising edge.
  always @(posedge clk) begin
    answer_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_beat(cur_beat);
      beat_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result beat: kind %0d label %0d", out_tuser, out_tdata[9:0]);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[9:0] !== want.label) begin
          $error("label: expected %0d, got %0d", want.label, out_tdata[9:0]);
          errors++;
        end
        if (out_tdata[10] !== want.dropped) begin
          $error("edges_dropped: expected %0d, got %0d", want.dropped, out_tdata[10]);
          errors++;
        end
      end
    end
  end

  // Edge and query driver.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0 && pending_beats[0].drain) begin
        // Hold off until every outstanding result has come back.
        if (awaited_answers.size() == 0) void'(pending_beats.pop_front());
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_tdata <= {2'b00, cur_beat.qvert, cur_beat.weight, cur_beat.dst, cur_beat.src};
        in_tuser <= cur_beat.oper;
        in_tlast <= cur_beat.last;
        in_tvalid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic push_edge(int unsigned s, int unsigned d, int unsigned w, bit lst);
    beat_t bt;
    bt.oper = OPER_LOAD;
    bt.src = s;
    bt.dst = d;
    bt.weight = w;
    bt.last = lst;
    bt.qvert = $urandom_range(0, 1023);
    bt.drain = 1'b0;
    pending_beats.push_back(bt);
  endtask

  task automatic push_query(int unsigned q);
    beat_t bt;
    bt.oper = OPER_QUERY;
    bt.src = $urandom_range(0, 1023);
    bt.dst = $urandom_range(0, 1023);
    bt.weight = $urandom_range(0, 65535);
    bt.last = $urandom_range(0, 1);
    bt.qvert = q;
    bt.drain = 1'b0;
    pending_beats.push_back(bt);
  endtask

  task automatic push_hold();
    beat_t bt;
    bt = '{default: '0};
    bt.drain = 1'b1;
    pending_beats.push_back(bt);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || awaited_answers.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_VERTEX_COUNT: vcount_reg = val & 32'h7FF;
      CFG_K_SCALED: k_reg = val & 32'hFFFFFF;
      CFG_MIN_SIZE: minsize_reg = val & 32'h7FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_vertex(int unsigned vc);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, vc - 1);
  endfunction

  initial begin
    int unsigned vc;
    int unsigned n;
    int unsigned wspan;
    int unsigned nq;
    // After reset every vertex is its own component.
    reset_forest();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Queries before any segmentation see single-vertex components.
    push_query(0);
    push_query(1023);
    push_hold();
    // A lone self loop is the whole graph.
    push_edge(5, 5, 0, 1'b1);
    push_query(5);
    write_reg(CFG_VERTEX_COUNT, 8);
    write_reg(CFG_MIN_SIZE, 0);
    write_reg(CFG_K_SCALED, 0);
    // Zero weight merges even with k of zero; extreme weight does not.
    push_edge(0, 1, 0, 1'b0);
    push_edge(2, 3, 65535, 1'b0);
    push_edge(3, 1023, 0, 1'b0);
    push_edge(1023, 1023, 65535, 1'b1);
    push_query(1);
    push_query(3);
    push_query(7);
    push_query(8);
    push_query(1023);
    write_reg(CFG_K_SCALED, 24'hFFFFFF);
    write_reg(CFG_MIN_SIZE, 1024);
    write_reg(CFG_VERTEX_COUNT, 0);
    push_edge(0, 1, 100, 1'b0);
    push_edge(1, 0, 100, 1'b1);
    push_query(0);
    push_query(1);
    write_reg(CFG_VERTEX_COUNT, 2047);
    write_reg(CFG_MIN_SIZE, 2047);
    push_edge(1023, 0, 65535, 1'b0);
    push_edge(512, 1023, 1, 1'b1);
    push_query(512);
    push_query(0);
    // Overfill the edge store; the marked beat is itself dropped.
    write_reg(CFG_VERTEX_COUNT, 8);
    write_reg(CFG_MIN_SIZE, 3);
    write_reg(CFG_K_SCALED, 300);
    for (int i = 0; i <= EDGE_CAP; i++) begin
      if (i % 16 == 0) push_edge($urandom_range(0, 7), $urandom_range(0, 7),
                                 $urandom_range(0, 1000), i == EDGE_CAP);
      else push_edge($urandom_range(8, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 65535), i == EDGE_CAP);
    end
    push_query(3);
    push_query(6);
    push_edge(1, 2, 5, 1'b0);
    push_query(2);
    push_edge(2, 3, 5, 1'b1);
    push_query(3);

    // Random graphs, each followed by queries on the resulting segments.
    while (random_beats < 1450) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_VERTEX_COUNT, $urandom_range(0, 7) == 0 ?
                  $urandom_range(0, 2047) : $urandom_range(2, 48));
        write_reg(CFG_K_SCALED, $urandom_range(0, 5) == 0 ?
                  $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 4000));
        write_reg(CFG_MIN_SIZE, $urandom_range(0, 9) == 0 ?
                  $urandom_range(0, 2047) : $urandom_range(0, 6));
      end
      if ($urandom_range(0, 9) == 0) push_hold();
      vc = live_vertices();
      if (vc > 64) vc = 64;
      n = $urandom_range(1, 40);
      wspan = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 2000);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0) push_query(pick_vertex(vc));
        else push_edge(pick_vertex(vc), pick_vertex(vc), $urandom_range(0, wspan), i == n - 1);
      end
      nq = $urandom_range(2, 12);
      for (int i = 0; i < nq; i++) push_query(pick_vertex(vc));
      random_beats += n + nq;
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/gbis_pkg.sv
sv/gbis_ram.sv
sv/gbis_div.sv
sv/gbis_ctrl.sv
sv/gbis_dp.sv
sv/graph_based_image_segmentation_core.sv
tb/sv/tb_graph_based_image_segmentation_core.sv
